@@ hw/rtl/kway_merge_run_selector_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the multiway merge run selector
// Clocked implication helpers with synchronous reset disable.
// ----------------------------------------------------------------------------
`ifndef KWAY_MERGE_RUN_SELECTOR_MACROS_SVH
`define KWAY_MERGE_RUN_SELECTOR_MACROS_SVH

// Same-cycle implication.
`define KMRS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define KMRS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/kmrs_pkg.sv @@
// ----------------------------------------------------------------------------
// kmrs_pkg
// Shared widths and defaults for the multiway merge run selector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package kmrs_pkg;

  localparam int WAYS_DEFAULT     = 20;
  localparam int TAPES_DEFAULT    = 20;
  localparam int KEY_BITS_DEFAULT = 32;

  localparam int WAY_W      = 5;   // way and from_way fields
  localparam int TAPE_OUT_W = 5;   // out_tape field
  localparam int RUN_LEN_W  = 32;  // run_length register and run counters

  localparam logic [RUN_LEN_W-1:0] RUN_LENGTH_RESET = RUN_LEN_W'(20);

endpackage

`default_nettype wire

@@ hw/rtl/kmrs_ifs.sv @@
// ----------------------------------------------------------------------------
// kmrs channel interfaces
// Valid/ready channels for head records, results and the run length write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface kmrs_in_if #(
  parameter int KEY_BITS = kmrs_pkg::KEY_BITS_DEFAULT
);
  logic                       valid;
  logic                       ready;
  logic [KEY_BITS-1:0]        key;
  logic [kmrs_pkg::WAY_W-1:0] way;
  logic                       exhausted;

  modport source (output valid, key, way, exhausted, input ready);
  modport sink   (input valid, key, way, exhausted, output ready);
endinterface

interface kmrs_out_if #(
  parameter int KEY_BITS = kmrs_pkg::KEY_BITS_DEFAULT
);
  logic                            valid;
  logic                            ready;
  logic [KEY_BITS-1:0]             out_key;
  logic [kmrs_pkg::WAY_W-1:0]      from_way;
  logic [kmrs_pkg::TAPE_OUT_W-1:0] out_tape;
  logic                            pass_done;

  modport source (output valid, out_key, from_way, out_tape, pass_done, input ready);
  modport sink   (input valid, out_key, from_way, out_tape, pass_done, output ready);
endinterface

interface kmrs_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [kmrs_pkg::RUN_LEN_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/kway_merge_run_selector.sv @@
// Flow: a head transaction that completes the head set gives its result after a scan of
//   all ways; a run switch adds a second scan. The block takes one head transaction at a
//   time, as the single key comparator walks the head store one way per cycle; the input is
//   not ready again until the sequencer is back in idle. The input stays ready while a
//   finished result waits in the output register.
// Reset: synchronous, clears ended/loaded/count-valid flags, the tape index and the output
//   valid, and sets run_length to 20; the head key and run count stores are not cleared.
// ----------------------------------------------------------------------------
// kway_merge_run_selector
// One pass of a balanced multiway merge: select the smallest eligible head.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kway_merge_run_selector #(
  parameter int WAYS     = kmrs_pkg::WAYS_DEFAULT,
  parameter int TAPES    = kmrs_pkg::TAPES_DEFAULT,
  parameter int KEY_BITS = kmrs_pkg::KEY_BITS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  kmrs_cfg_if.sink   cfg,
  kmrs_in_if.sink    src,
  kmrs_out_if.source dst
);

  import kmrs_pkg::*;

  localparam int WIDX = $clog2(WAYS);
  localparam int TIDX = $clog2(TAPES);
  localparam logic [WIDX-1:0] LAST_WAY  = WIDX'(WAYS - 1);
  localparam logic [TIDX-1:0] LAST_TAPE = TIDX'(TAPES - 1);

  // Sequencer states, one-hot.
  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,  // wait for a head transaction
    ST_CHECK  = 5'b00010,  // all heads present? all ways ended?
    ST_SCAN   = 5'b00100,  // issue one head store read per cycle
    ST_FINISH = 5'b01000,  // compare the last way read
    ST_DECIDE = 5'b10000   // emit the winner or switch the run and rescan
  } state_t;

  state_t state;

  // Configuration and per-way flags.
  logic [RUN_LEN_W-1:0] run_length;
  logic [WAYS-1:0]      ended;
  logic [WAYS-1:0]      loaded;
  logic [WAYS-1:0]      cnt_vld;    // run count entry valid; invalid reads as zero
  logic [TIDX-1:0]      tape;
  logic                 item_ok;    // accepted way was in range

  // Head key and run count stores: one write port, one registered read port.
  logic [KEY_BITS-1:0]  head_mem [WAYS];
  logic [RUN_LEN_W-1:0] cnt_mem  [WAYS];

  // Scan pipeline.
  logic [WIDX-1:0]      scan_idx;
  logic                 cmp_vld;
  logic [WIDX-1:0]      cmp_idx;
  logic [KEY_BITS-1:0]  key_q;
  logic [RUN_LEN_W-1:0] cnt_q;
  logic                 cvld_q;
  logic                 end_q;

  // Running minimum.
  logic                 found;
  logic [WIDX-1:0]      best_idx;
  logic [KEY_BITS-1:0]  best_key;
  logic [RUN_LEN_W-1:0] best_cnt;

  // Output register.
  logic                 res_vld;
  logic [KEY_BITS-1:0]  res_key;
  logic [WAY_W-1:0]     res_way;
  logic [TAPE_OUT_W-1:0] res_tape;
  logic                 res_done;

  // Combinational helpers.
  logic                   acc;
  logic                   way_ok;
  logic [WIDX+WAY_W-1:0]  way_ext;
  logic [WIDX-1:0]        w_idx;
  logic                   head_we;
  logic [RUN_LEN_W-1:0]   lim;
  logic [RUN_LEN_W-1:0]   cnt_cur;
  logic                   elig;
  logic                   better;
  logic                   out_free;
  logic                   emit_rec;
  logic                   emit_done;
  logic                   res_load;
  logic [TIDX-1:0]        tape_next;
  logic [TAPE_OUT_W+TIDX-1:0] tape_ext;
  logic [WAY_W+WIDX-1:0]  best_ext;

  assign acc     = src.valid && src.ready;
  assign way_ok  = (int'(src.way) < WAYS);
  assign way_ext = {{WIDX{1'b0}}, src.way};
  assign w_idx   = way_ext[WIDX-1:0];
  // Ended ways keep their last key; exhaust marks never write a key.
  assign head_we = acc && way_ok && !ended[w_idx] && !src.exhausted;

  // A run length of zero behaves as one.
  assign lim     = (run_length == '0) ? RUN_LEN_W'(1) : run_length;
  assign cnt_cur = cvld_q ? cnt_q : '0;
  assign elig    = cmp_vld && !end_q && (cnt_cur < lim);
  assign better  = !found || (key_q < best_key);

  // The output register can take a new result when empty or being drained.
  assign out_free  = !res_vld || dst.ready;
  assign emit_rec  = (state == ST_DECIDE) && found && out_free;
  assign emit_done = (state == ST_CHECK) && item_ok && (&loaded) && (&ended) && out_free;
  assign res_load  = emit_rec || emit_done;

  assign tape_next = (tape == LAST_TAPE) ? '0 : tape + 1'b1;
  assign tape_ext  = {{TAPE_OUT_W{1'b0}}, tape};
  assign best_ext  = {{WAY_W{1'b0}}, best_idx};

  assign src.ready = (state == ST_IDLE);
  assign cfg.ready = 1'b1;

  assign dst.valid     = res_vld;
  assign dst.out_key   = res_key;
  assign dst.from_way  = res_way;
  assign dst.out_tape  = res_tape;
  assign dst.pass_done = res_done;

  // Head store: write on a keyed transaction, read at the scan pointer.
  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[w_idx] <= src.key;
    end
    key_q <= head_mem[scan_idx];
  end

  // Run count store: bump the winner's count, read at the scan pointer.
  always_ff @(posedge clk) begin
    if (emit_rec) begin
      cnt_mem[best_idx] <= best_cnt + 1'b1;
    end
    cnt_q <= cnt_mem[scan_idx];
  end

  // Flags that travel with the read data.
  always_ff @(posedge clk) begin
    cvld_q  <= cnt_vld[scan_idx];
    end_q   <= ended[scan_idx];
    cmp_idx <= scan_idx;
  end

  // Running minimum over the scanned ways; ties keep the lower way.
  always_ff @(posedge clk) begin
    if (elig && better) begin
      best_idx <= cmp_idx;
      best_key <= key_q;
      best_cnt <= cnt_cur;
    end
  end

  // Main sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      run_length <= RUN_LENGTH_RESET;
      ended      <= '0;
      loaded     <= '0;
      cnt_vld    <= '0;
      tape       <= '0;
      item_ok    <= 1'b0;
      cmp_vld    <= 1'b0;
      found      <= 1'b0;
      scan_idx   <= '0;
      res_vld    <= 1'b0;
    end else begin
      if (cfg.valid) begin
        run_length <= cfg.data;
      end

      // Load a new result, or drop the current one once the sink takes it.
      if (res_load) begin
        res_vld <= 1'b1;
      end else if (res_vld && dst.ready) begin
        res_vld <= 1'b0;
      end

      cmp_vld <= (state == ST_SCAN);
      if (elig && better) begin
        found <= 1'b1;
      end

      unique case (state)
        ST_IDLE: begin
          if (acc) begin
            item_ok <= way_ok;
            if (way_ok) begin
              if (!ended[w_idx] && src.exhausted) begin
                ended[w_idx] <= 1'b1;
              end
              loaded[w_idx] <= 1'b1;
            end
            state <= ST_CHECK;
          end
        end

        ST_CHECK: begin
          if (!item_ok || !(&loaded)) begin
            state <= ST_IDLE;
          end else if (&ended) begin
            // Every way ended: report pass done, change nothing.
            if (out_free) begin
              res_key  <= '0;
              res_way  <= '0;
              res_tape <= tape_ext[TAPE_OUT_W-1:0];
              res_done <= 1'b1;
              state    <= ST_IDLE;
            end
          end else begin
            found    <= 1'b0;
            scan_idx <= '0;
            state    <= ST_SCAN;
          end
        end

        ST_SCAN: begin
          scan_idx <= scan_idx + 1'b1;
          if (scan_idx == LAST_WAY) begin
            state <= ST_FINISH;
          end
        end

        ST_FINISH: begin
          state <= ST_DECIDE;
        end

        ST_DECIDE: begin
          if (found) begin
            // Hold until the output register frees up.
            if (out_free) begin
              res_key  <= best_key;
              res_way  <= best_ext[WAY_W-1:0];
              res_tape <= tape_ext[TAPE_OUT_W-1:0];
              res_done <= 1'b0;
              cnt_vld[best_idx] <= 1'b1;
              loaded[best_idx]  <= 1'b0;
              state    <= ST_IDLE;
            end
          end else begin
            // No eligible way: advance the tape, clear counts, rescan.
            tape     <= tape_next;
            cnt_vld  <= '0;
            found    <= 1'b0;
            scan_idx <= '0;
            state    <= ST_SCAN;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/kmrs_checker.sv @@
// ----------------------------------------------------------------------------
// kmrs_checker
// Port-level checks for the multiway merge run selector, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "kway_merge_run_selector_macros.svh"

module kmrs_checker #(
  parameter int KEY_BITS = kmrs_pkg::KEY_BITS_DEFAULT
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       src_valid,
  input logic                       src_ready,
  input logic                       dst_valid,
  input logic                       dst_ready,
  input logic [KEY_BITS-1:0]        out_key,
  input logic [kmrs_pkg::WAY_W-1:0] from_way,
  input logic                       pass_done
);

  import kmrs_pkg::*;

  // The sequencer is busy right after taking a head.
  `KMRS_ASSERT_NXT(a_busy_after_accept, clk, rst, src_valid && src_ready, !src_ready, "input still ready after accept")

  // A new result only appears after the block was busy.
  `KMRS_ASSERT_IMP(a_result_after_work, clk, rst, $rose(dst_valid), !$past(src_ready), "result rose while idle")

  // Pass done carries no record.
  `KMRS_ASSERT_IMP(a_pass_done_empty, clk, rst, dst_valid && pass_done, (out_key == '0) && (from_way == '0), "pass done with record payload")

  // A stalled result holds.
  `KMRS_ASSERT_NXT(a_result_hold, clk, rst, dst_valid && !dst_ready, dst_valid && $stable(out_key) && $stable(from_way) && $stable(pass_done), "stalled result changed")

endmodule

bind kway_merge_run_selector kmrs_checker #(
  .KEY_BITS (KEY_BITS)
) u_kmrs_checker (
  .clk       (clk),
  .rst       (rst),
  .src_valid (src.valid),
  .src_ready (src.ready),
  .dst_valid (dst.valid),
  .dst_ready (dst.ready),
  .out_key   (dst.out_key),
  .from_way  (dst.from_way),
  .pass_done (dst.pass_done)
);

`default_nettype wire

@@ dv/kway_merge_run_selector_tb.sv @@
// ----------------------------------------------------------------------------
// kway_merge_run_selector_tb
// Self-checking bench for the multiway merge run selector: refills way heads
// the way a merge pass does, mixes in noise, and checks each emitted pick.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kway_merge_run_selector_tb;
  import kmrs_pkg::*;

  localparam int WAYS        = WAYS_DEFAULT;
  localparam int TAPES       = TAPES_DEFAULT;
  localparam int KEY_BITS    = KEY_BITS_DEFAULT;
  // A result is ready after a scan of all ways once a transaction completes the
  // head set; a run switch adds a second scan. Allow for both, with margin.
  localparam int SETTLE      = 2 * WAYS + 20;
  localparam int HOLD_CYCLES = 600;
  localparam int IDLE_LIMIT  = 4000;

  typedef struct packed {
    logic [KEY_BITS-1:0]   key;
    logic [WAY_W-1:0]      way;
    logic [TAPE_OUT_W-1:0] tape;
    logic                  pass_done;
  } pick_t;

  // Tracks the head store, run counters and output tape, and holds the picks
  // the block owes us in acceptance order.
  class run_merge_tracker;
    logic [KEY_BITS-1:0]   head_key [WAYS];
    bit                    ended    [WAYS];
    bit                    loaded   [WAYS];
    logic [RUN_LEN_W-1:0]  run_cnt  [WAYS];
    logic [TAPE_OUT_W-1:0] tape;
    logic [RUN_LEN_W-1:0]  run_len;
    pick_t                 pending_picks [$];
    int                    errors;

    function new();
      for (int i = 0; i < WAYS; i++) begin
        head_key[i] = '0;
        ended[i]    = 1'b0;
        loaded[i]   = 1'b0;
        run_cnt[i]  = '0;
      end
      tape    = '0;
      run_len = RUN_LENGTH_RESET;
      errors  = 0;
    endfunction

    function void set_run_length(input logic [RUN_LEN_W-1:0] v);
      run_len = v;
    endfunction

    function logic [RUN_LEN_W-1:0] quota();
      return (run_len == '0) ? RUN_LEN_W'(1) : run_len;
    endfunction

    function int live_ways();
      int n;
      n = 0;
      for (int i = 0; i < WAYS; i++) if (!ended[i]) n++;
      return n;
    endfunction

    // Lowest way still waiting for a head, or -1.
    function int open_way();
      for (int i = 0; i < WAYS; i++) if (!loaded[i]) return i;
      return -1;
    endfunction

    function void note_head(input logic [KEY_BITS-1:0] key, input logic [WAY_W-1:0] way,
                            input logic exhausted);
      bit all_ended;
      bit run_over;
      int best;
      pick_t p;
      if (int'(way) >= WAYS) return;
      // An ended way stays ended; later transactions only mark it loaded.
      if (!ended[way]) begin
        if (exhausted) ended[way] = 1'b1;
        else head_key[way] = key;
      end
      loaded[way] = 1'b1;
      for (int i = 0; i < WAYS; i++) if (!loaded[i]) return;

      all_ended = 1'b1;
      run_over  = 1'b1;
      for (int i = 0; i < WAYS; i++) begin
        if (!ended[i]) all_ended = 1'b0;
        if (!ended[i] && run_cnt[i] < quota()) run_over = 1'b0;
      end
      if (all_ended) begin
        p = '{key: '0, way: '0, tape: tape, pass_done: 1'b1};
        pending_picks.push_back(p);
        return;
      end
      // Every live way used up its run: advance to the next output tape.
      if (run_over) begin
        tape = TAPE_OUT_W'((int'(tape) + 1) % TAPES);
        for (int i = 0; i < WAYS; i++) run_cnt[i] = '0;
      end
      best = -1;
      for (int i = 0; i < WAYS; i++) begin
        if (ended[i] || run_cnt[i] >= quota()) continue;
        if (best < 0 || head_key[i] < head_key[best]) best = i;
      end
      p = '{key: head_key[best], way: WAY_W'(best), tape: tape, pass_done: 1'b0};
      pending_picks.push_back(p);
      run_cnt[best] = run_cnt[best] + 1'b1;
      loaded[best]  = 1'b0;
    endfunction

    task report(input string msg);
      errors++;
      $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    task check_pick(input pick_t got);
      pick_t want;
      if (pending_picks.size() == 0) begin
        report($sformatf("unexpected result key=%h way=%0d tape=%0d pass_done=%0b",
                         got.key, got.way, got.tape, got.pass_done));
        return;
      end
      want = pending_picks.pop_front();
      if (got.key !== want.key)
        report($sformatf("out_key %h, expected %h", got.key, want.key));
      if (got.way !== want.way)
        report($sformatf("from_way %0d, expected %0d", got.way, want.way));
      if (got.tape !== want.tape)
        report($sformatf("out_tape %0d, expected %0d", got.tape, want.tape));
      if (got.pass_done !== want.pass_done)
        report($sformatf("pass_done %0b, expected %0b", got.pass_done, want.pass_done));
    endtask
  endclass

  logic clk;
  logic rst;

  kmrs_cfg_if                         cfg_ch ();
  kmrs_in_if  #(.KEY_BITS(KEY_BITS))  in_ch  ();
  kmrs_out_if #(.KEY_BITS(KEY_BITS))  out_ch ();

  kway_merge_run_selector #(
    .WAYS    (WAYS),
    .TAPES   (TAPES),
    .KEY_BITS(KEY_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg(cfg_ch),
    .src(in_ch),
    .dst(out_ch)
  );

  run_merge_tracker trk;

  // Idle percentages for each side, changed per phase by the main sequence.
  int tx_idle_pct;
  int rx_idle_pct;
  // Pulse to ask the receiver for one long hold-off.
  logic hold_req;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Mostly short gaps, now and then a long one.
  function automatic int idle_len();
    if ($urandom_range(99) < 85) return $urandom_range(1, 3);
    return $urandom_range(12, 60);
  endfunction

  // Keys: full random, the two extremes, and a narrow band that forces ties.
  function automatic logic [KEY_BITS-1:0] draw_key();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3:    return KEY_BITS'($urandom_range(0, 15));
      default: return KEY_BITS'($urandom);
    endcase
  endfunction

  // Offer one head transaction, hold it until accepted, then maybe go idle.
  task automatic send_head(input logic [KEY_BITS-1:0] k, input logic [WAY_W-1:0] w,
                           input logic x);
    int gap;
    in_ch.valid     <= 1'b1;
    in_ch.key       <= k;
    in_ch.way       <= w;
    in_ch.exhausted <= x;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    trk.note_head(k, w, x);
    gap = 0;
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) gap = idle_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and step one cycle so a later raise lands in a new time step.
  task automatic pause_tx();
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (trk.pending_picks.size() != 0) @(posedge clk);
  endtask

  // Write run_length only with the block idle: nothing owed and no scan running.
  task automatic write_run_length(input logic [RUN_LEN_W-1:0] v);
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    trk.set_run_length(v);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // One random phase. Most transactions refill the way the last pick freed,
  // the rest are reloads of random ways and out-of-range noise. A few refills
  // end their way, as long as enough ways stay live to keep the merge going.
  task automatic run_phase(input int n_items, input int tx_pct, input int rx_pct,
                           input bit hold, input bit mid_drain);
    int sent;
    int w;
    int r;
    logic x;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    if (hold) hold_req <= 1'b1;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(99);
      x = 1'b0;
      if (r < 5) begin
        // Ignored by the block, so not counted.
        send_head(draw_key(), WAY_W'($urandom_range(WAYS, 31)), 1'($urandom_range(1)));
        continue;
      end
      if (r < 15) begin
        w = $urandom_range(WAYS - 1);
      end else begin
        w = trk.open_way();
        if (w < 0) w = $urandom_range(WAYS - 1);
      end
      if (trk.ended[w]) x = 1'($urandom_range(1));
      else if (trk.live_ways() > 4 && $urandom_range(99) == 0) x = 1'b1;
      send_head(draw_key(), WAY_W'(w), x);
      sent++;
      // Sender waits out every owed pick once mid-phase.
      if (mid_drain && sent == n_items / 2) begin
        pause_tx();
        wait_drained();
      end
    end
    pause_tx();
    wait_drained();
  endtask

  // Receiver: check each accepted result, then choose ready for the next edge.
  initial begin : receiver
    int stall_left;
    pick_t got;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got = '{key: out_ch.out_key, way: out_ch.from_way, tape: out_ch.out_tape,
                pass_done: out_ch.pass_done};
        trk.check_pick(got);
      end
      if (hold_req === 1'b1) begin
        hold_req   <= 1'b0;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && rx_idle_pct != 0 && $urandom_range(99) < rx_idle_pct) begin
        stall_left = idle_len();
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run if no channel moves a transaction for too long.
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid & in_ch.ready) === 1'b1 || (out_ch.valid & out_ch.ready) === 1'b1 ||
          (cfg_ch.valid & cfg_ch.ready) === 1'b1)
        idle = 0;
      else
        idle++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin : main_seq
    trk = new();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req        <= 1'b0;
    rst             <= 1'b1;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.data     <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.key       <= '0;
    in_ch.way       <= '0;
    in_ch.exhausted <= 1'b0;
    out_ch.ready    <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset run length.
    tx_idle_pct = 20;
    rx_idle_pct = 20;
    // Out-of-range ways are dropped.
    send_head(KEY_BITS'(32'h1234_5678), WAY_W'(25), 1'b0);
    send_head('1, WAY_W'(31), 1'b1);
    // Way 5 gets a head now and is reloaded with a smaller key below.
    send_head(KEY_BITS'(100), WAY_W'(5), 1'b0);
    // Fill every way: extremes on 0 and 1, a tie between ways 1 and 2.
    for (int i = 0; i < WAYS; i++) begin
      if (i == 0)               send_head('1, WAY_W'(i), 1'b0);
      else if (i == 1 || i == 2) send_head('0, WAY_W'(i), 1'b0);
      else if (i == 5)          send_head(KEY_BITS'(50), WAY_W'(i), 1'b0);
      else                      send_head(KEY_BITS'(1000 + i), WAY_W'(i), 1'b0);
    end
    // Refill way 1 with the same key: the tie goes to way 1 again.
    send_head('0, WAY_W'(1), 1'b0);
    // End way 1; the pick falls to way 2.
    send_head('0, WAY_W'(1), 1'b1);
    // A record for the ended way only marks it loaded.
    send_head(KEY_BITS'(7), WAY_W'(1), 1'b0);
    send_head('1, WAY_W'(2), 1'b0);
    pause_tx();
    wait_drained();

    // Run length 1: a run switch almost every live-way count of picks, and the
    // tape index advances with each switch.
    write_run_length(RUN_LEN_W'(1));
    run_phase(250, 30, 30, 1'b0, 1'b0);

    // Zero acts as one. Receiver holds off long while the sender keeps pushing.
    write_run_length('0);
    run_phase(200, 0, 10, 1'b1, 1'b0);

    // Largest run length: no switches. No idling at all, drain mid-phase.
    write_run_length('1);
    run_phase(200, 0, 0, 1'b0, 1'b1);

    write_run_length(RUN_LEN_W'(3));
    run_phase(250, 25, 25, 1'b0, 1'b0);

    write_run_length(RUN_LEN_W'(20));
    run_phase(250, 10, 60, 1'b0, 1'b0);

    write_run_length(RUN_LEN_W'($urandom_range(2, 7)));
    run_phase(250, 40, 20, 1'b0, 1'b0);

    // End every remaining way through the refills, then the pass is done and
    // every in-range transaction returns pass_done.
    write_run_length(RUN_LEN_W'(2));
    tx_idle_pct = 20;
    rx_idle_pct = 20;
    while (trk.live_ways() > 0 && trk.open_way() >= 0)
      send_head(draw_key(), WAY_W'(trk.open_way()), 1'b1);
    for (int i = 0; i < 4; i++)
      send_head(draw_key(), WAY_W'($urandom_range(WAYS - 1)), 1'($urandom_range(1)));
    send_head(draw_key(), WAY_W'($urandom_range(WAYS, 31)), 1'b0);
    pause_tx();
    wait_drained();
    repeat (SETTLE) @(posedge clk);

    if (trk.errors == 0 && trk.pending_picks.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
